>>> src/dense_layer_train_step_top_macros.svh
// Assertion macros for the dense layer training block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef DENSE_LAYER_TRAIN_STEP_TOP_MACROS_SVH
`define DENSE_LAYER_TRAIN_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLTS_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dense layer check failed");

// Next-cycle implication, disabled during reset.
`define DLTS_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dense layer check failed");

`endif

>>> src/dlts_pkg.sv
// Shared types, codes and saturation helpers for the dense layer training block.
// No dependencies.
package dlts_pkg;

  localparam int DATA_W  = 32;
  localparam int GRAD_W  = 48;
  localparam int LR_W    = 16;
  localparam int COL_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 56;
  localparam int RES_CAP = 16;
  localparam int RES_IW  = 4;
  localparam logic [LR_W-1:0] LR_RESET = 16'd655;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_GRAD   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;
  localparam logic [1:0] KIND_BIAS   = 2'd3;

  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_FWD = 3'd1;
  localparam logic [2:0] OP_BWD = 3'd2;
  localparam logic [2:0] OP_UPW = 3'd3;
  localparam logic [2:0] OP_UPB = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic [COL_W-1:0]        col;
    logic signed [DATA_W-1:0] x;
    logic signed [SUM_W-1:0]  psum;
  } tok_t;

  typedef struct packed {
    logic                    w_we;
    logic                    b_we;
    logic                    g_we;
    logic                    g_clr;
    logic                    res_load;
    logic [COL_W-1:0]        sel;
    logic [COL_W-1:0]        col;
    logic [CNT_W-1:0]        clr_from;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic fwd;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < 64'shFFFFFFFF80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (v < 64'shFFFF800000000000) return 48'sh800000000000;
    return v[47:0];
  endfunction

endpackage

>>> src/dlts_cell.sv
// One neuron cell of the chain: weight row, bias, gradient sums and a two-stage MAC.
// Depends on dlts_pkg.
module dlts_cell #(
  parameter int IN_SIZE = 16,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dlts_pkg::tok_t       tk_i,
  output dlts_pkg::tok_t       tk_o,
  input  dlts_pkg::cmd_t       cmd,
  input  logic [15:0]          lr,
  input  logic signed [31:0]   res_i,
  output logic signed [31:0]   res_o,
  input  logic                 res_shift
);
  localparam int IW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int SW = dlts_pkg::SUM_W;

  logic signed [31:0] w_mem [IN_SIZE];
  logic signed [47:0] wg_mem [IN_SIZE];
  logic [IN_SIZE-1:0] wg_vld_r;
  logic signed [31:0] bias_r;
  logic signed [47:0] bg_r;
  logic signed [31:0] g_r;
  logic signed [SW-1:0] acc_r;
  logic signed [31:0] res_r;
  dlts_pkg::tok_t s1_r, tk_r, tk_nxt;
  logic signed [63:0] p1_r, p2_r;
  logic signed [64:0] pu_r;
  logic signed [31:0] wrd_r;
  logic signed [47:0] wgd_r;

  logic [IW-1:0] col_i, c1;
  logic signed [31:0] w_rd, mul_b;
  logic signed [47:0] wg_rd, q1, q2, wg_sum, bg_sum;
  logic signed [48:0] step;
  logic signed [31:0] new_w, new_b;
  logic hit, w_we;
  logic [IW-1:0] w_wa;
  logic signed [31:0] w_wd;

  always_comb begin
    col_i  = tk_i.col[IW-1:0];
    c1     = s1_r.col[IW-1:0];
    w_rd   = w_mem[col_i];
    wg_rd  = wg_vld_r[col_i] ? wg_mem[col_i] : 48'sd0;
    mul_b  = (tk_i.op == dlts_pkg::OP_FWD) ? tk_i.x : g_r;
    q1     = $signed(p1_r[63:16]);
    q2     = $signed(p2_r[63:16]);
    step   = $signed(pu_r[64:16]);
    wg_sum = dlts_pkg::sat48(64'(wgd_r) + 64'(q2));
    bg_sum = dlts_pkg::sat48(64'(bg_r) + 64'(g_r));
    new_w  = dlts_pkg::sat32(64'(wrd_r) - 64'(step));
    new_b  = dlts_pkg::sat32(64'(bias_r) - 64'(step));
    hit    = (cmd.sel == dlts_pkg::COL_W'(IDX));
    w_we   = (s1_r.op == dlts_pkg::OP_UPW) || (cmd.w_we && hit);
    w_wa   = (s1_r.op == dlts_pkg::OP_UPW) ? c1 : cmd.col[IW-1:0];
    w_wd   = (s1_r.op == dlts_pkg::OP_UPW) ? new_w : cmd.data;
    tk_nxt = s1_r;
    tk_nxt.psum = s1_r.psum + SW'(q1);
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    if (s1_r.op == dlts_pkg::OP_BWD) begin
      wg_mem[c1] <= wg_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wg_vld_r <= '0;
      bias_r   <= '0;
      bg_r     <= '0;
      s1_r.op  <= dlts_pkg::OP_NOP;
      tk_r.op  <= dlts_pkg::OP_NOP;
    end else begin
      s1_r <= tk_i;
      tk_r <= tk_nxt;
      if (s1_r.op == dlts_pkg::OP_BWD) begin
        wg_vld_r[c1] <= 1'b1;
        if (s1_r.col == '0) begin
          bg_r <= bg_sum;
        end
      end else if (s1_r.op == dlts_pkg::OP_UPW) begin
        wg_vld_r[c1] <= 1'b0;
      end
      if (s1_r.op == dlts_pkg::OP_UPB) begin
        bias_r <= new_b;
        bg_r   <= '0;
      end else if (cmd.b_we && hit) begin
        bias_r <= cmd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= w_rd * mul_b;
    p2_r  <= g_r * tk_i.x;
    pu_r  <= ((tk_i.op == dlts_pkg::OP_UPB) ? bg_r : wg_rd) * $signed({1'b0, lr});
    wrd_r <= w_rd;
    wgd_r <= wg_rd;
    if (cmd.g_we && hit) begin
      g_r <= cmd.data;
    end else if (cmd.g_clr && (dlts_pkg::CNT_W'(IDX) >= cmd.clr_from)) begin
      g_r <= '0;
    end
    if (s1_r.op == dlts_pkg::OP_FWD) begin
      acc_r <= ((s1_r.col == '0) ? SW'(bias_r) : acc_r) + SW'(q1);
    end
    if (cmd.res_load) begin
      res_r <= dlts_pkg::sat32(64'(acc_r));
    end else if (res_shift) begin
      res_r <= res_i;
    end
  end

  assign tk_o  = tk_r;
  assign res_o = res_r;

endmodule

>>> src/dlts_ctl.sv
// Input handling, sample row memory and column sequencer feeding the cell chain.
// Depends on dlts_pkg.
module dlts_ctl #(
  parameter int IN_SIZE = 16,
  parameter int OUT_SIZE = 16,
  parameter int BATCH_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_value,
  input  logic                in_row_end,
  input  logic                in_batch_end,
  input  logic [3:0]          in_out_index,
  input  logic [3:0]          in_in_index,
  output dlts_pkg::cmd_t      cmd,
  output dlts_pkg::tok_t      tok,
  output dlts_pkg::stat_t     stat,
  input  logic                emit_done
);
  localparam int DEPTH   = BATCH_MAX * IN_SIZE;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
  localparam int DRAIN_N = 2 * OUT_SIZE + 2;
  localparam int DCW     = $clog2(DRAIN_N + 1);
  localparam int CW      = dlts_pkg::CNT_W;
  localparam int KW      = dlts_pkg::COL_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_GAP   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt, fill_r, fill_nxt, iss_r, iss_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt, row_sel_r, row_sel_nxt, row_next;
  logic fwd_r, fwd_nxt, batch_r, batch_nxt;
  logic [DCW-1:0] drain_r, drain_nxt;
  logic [2:0] pv_op_r, pv_op_nxt;
  logic [KW-1:0] pv_col_r, pv_col_nxt;
  logic pv_zero_r, pv_zero_nxt;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra, base;
  logic signed [31:0] mem_wd;
  logic [RW-1:0] base_row;
  logic accept;

  always_comb begin
    accept   = in_valid && (state_r == S_IDLE);
    base_row = (state_r == S_IDLE) ? row_cnt_r : row_sel_r;
    base     = AW'(base_row) * AW'(IN_SIZE);
    mem_ra   = base + AW'(iss_r);
    if (in_batch_end || (row_cnt_r == RW'(BATCH_MAX - 1))) begin
      row_next = '0;
    end else begin
      row_next = row_cnt_r + 1'b1;
    end

    state_nxt   = state_r;
    col_cnt_nxt = col_cnt_r;
    fill_nxt    = fill_r;
    iss_nxt     = iss_r;
    row_cnt_nxt = row_cnt_r;
    row_sel_nxt = row_sel_r;
    fwd_nxt     = fwd_r;
    batch_nxt   = batch_r;
    drain_nxt   = drain_r;
    pv_op_nxt   = dlts_pkg::OP_NOP;
    pv_col_nxt  = iss_r[KW-1:0];
    pv_zero_nxt = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = base + AW'(col_cnt_r);
    mem_wd      = in_value;
    cmd         = '0;
    cmd.data    = in_value;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            dlts_pkg::KIND_SAMPLE: begin
              if (col_cnt_r < CW'(IN_SIZE)) begin
                mem_we      = 1'b1;
                col_cnt_nxt = col_cnt_r + 1'b1;
              end
              if (in_row_end) begin
                fill_nxt    = col_cnt_nxt;
                col_cnt_nxt = '0;
                fwd_nxt     = 1'b1;
                batch_nxt   = in_batch_end;
                row_sel_nxt = row_cnt_r;
                row_cnt_nxt = row_next;
                iss_nxt     = '0;
                state_nxt   = S_SWEEP;
              end
            end
            dlts_pkg::KIND_GRAD: begin
              if (col_cnt_r < CW'(OUT_SIZE)) begin
                cmd.g_we    = 1'b1;
                cmd.sel     = col_cnt_r[KW-1:0];
                col_cnt_nxt = col_cnt_r + 1'b1;
              end
              if (in_row_end) begin
                cmd.g_clr    = 1'b1;
                cmd.clr_from = col_cnt_nxt;
                col_cnt_nxt  = '0;
                fwd_nxt      = 1'b0;
                batch_nxt    = in_batch_end;
                row_sel_nxt  = row_cnt_r;
                row_cnt_nxt  = row_next;
                iss_nxt      = '0;
                state_nxt    = S_SWEEP;
              end
            end
            dlts_pkg::KIND_WEIGHT: begin
              cmd.w_we = (CW'(in_out_index) < CW'(OUT_SIZE)) &&
                         (CW'(in_in_index) < CW'(IN_SIZE));
              cmd.sel  = KW'(in_out_index);
              cmd.col  = KW'(in_in_index);
            end
            dlts_pkg::KIND_BIAS: begin
              cmd.b_we = (CW'(in_out_index) < CW'(OUT_SIZE));
              cmd.sel  = KW'(in_out_index);
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        pv_op_nxt   = fwd_r ? dlts_pkg::OP_FWD : dlts_pkg::OP_BWD;
        pv_zero_nxt = fwd_r && (iss_r >= fill_r);
        if (pv_zero_nxt) begin
          mem_we = 1'b1;
          mem_wa = mem_ra;
          mem_wd = '0;
        end
        iss_nxt = iss_r + 1'b1;
        if (iss_r == CW'(IN_SIZE - 1)) begin
          iss_nxt   = '0;
          drain_nxt = '0;
          state_nxt = (!fwd_r && batch_r) ? S_GAP : S_DRAIN;
        end
      end
      S_GAP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        iss_nxt = iss_r + 1'b1;
        if (iss_r == CW'(IN_SIZE)) begin
          pv_op_nxt  = dlts_pkg::OP_UPB;
          pv_col_nxt = '0;
          iss_nxt    = '0;
          drain_nxt  = '0;
          state_nxt  = S_DRAIN;
        end else begin
          pv_op_nxt = dlts_pkg::OP_UPW;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DCW'(DRAIN_N - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      iss_r     <= '0;
      drain_r   <= '0;
      fill_r    <= '0;
      row_sel_r <= '0;
      fwd_r     <= 1'b0;
      batch_r   <= 1'b0;
      pv_op_r   <= dlts_pkg::OP_NOP;
    end else begin
      state_r   <= state_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      iss_r     <= iss_nxt;
      drain_r   <= drain_nxt;
      fill_r    <= fill_nxt;
      row_sel_r <= row_sel_nxt;
      fwd_r     <= fwd_nxt;
      batch_r   <= batch_nxt;
      pv_op_r   <= pv_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_col_r  <= pv_col_nxt;
    pv_zero_r <= pv_zero_nxt;
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    stat.emit = (state_r == S_EMIT);
    stat.fwd  = fwd_r;
    tok.op    = pv_op_r;
    tok.col   = pv_col_r;
    tok.x     = pv_zero_r ? 32'sd0 : rdata_r;
    tok.psum  = '0;
  end

endmodule

>>> src/dense_layer_train_step_top.sv
// Dense layer with SGD training: after a row end the input stalls while the row runs through
// the cell chain, then one result per cycle is emitted while out_stall is low; a batch end on
// a gradient row adds a weight and bias update pass. The chain of OUT_SIZE cells, two stages
// each, sets the row latency. Synchronous active-low reset clears control state, biases and
// gradient sums, and sets the learning rate to 655; weights and sample rows are undefined
// until written. Depends on dlts_pkg, dlts_ctl, dlts_cell and the assertion macro header.
`include "dense_layer_train_step_top_macros.svh"
module dense_layer_train_step_top #(
  parameter int IN_SIZE = 16,
  parameter int OUT_SIZE = 16,
  parameter int BATCH_MAX = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_value,
  input  logic                in_row_end,
  input  logic                in_batch_end,
  input  logic [3:0]          in_out_index,
  input  logic [3:0]          in_in_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result_value,
  output logic [3:0]          out_result_index,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  localparam int NF = (OUT_SIZE < dlts_pkg::RES_CAP) ? OUT_SIZE : dlts_pkg::RES_CAP;
  localparam int NB = (IN_SIZE < dlts_pkg::RES_CAP) ? IN_SIZE : dlts_pkg::RES_CAP;
  localparam int RI = dlts_pkg::RES_IW;

  dlts_pkg::cmd_t  cmd;
  dlts_pkg::stat_t stat;
  dlts_pkg::tok_t  tk_w [OUT_SIZE+1];
  logic signed [31:0] res_w [OUT_SIZE+1];
  logic [15:0] lr_r;
  logic [RI-1:0] k_r;
  logic signed [31:0] obuf_r [dlts_pkg::RES_CAP];
  logic out_acc, res_shift, emit_done;
  dlts_pkg::tok_t tail;

  dlts_ctl #(
    .IN_SIZE(IN_SIZE),
    .OUT_SIZE(OUT_SIZE),
    .BATCH_MAX(BATCH_MAX)
  ) u_ctl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_value(in_value),
    .in_row_end(in_row_end),
    .in_batch_end(in_batch_end),
    .in_out_index(in_out_index),
    .in_in_index(in_in_index),
    .cmd(cmd),
    .tok(tk_w[0]),
    .stat(stat),
    .emit_done(emit_done)
  );

  assign res_w[OUT_SIZE] = '0;

  for (genvar o = 0; o < OUT_SIZE; o++) begin : g_cell
    dlts_cell #(
      .IN_SIZE(IN_SIZE),
      .IDX(o)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .tk_i(tk_w[o]),
      .tk_o(tk_w[o+1]),
      .cmd(cmd),
      .lr(lr_r),
      .res_i(res_w[o+1]),
      .res_o(res_w[o]),
      .res_shift(res_shift)
    );
  end

  assign tail = tk_w[OUT_SIZE];

  always_ff @(posedge clk) begin
    if ((tail.op == dlts_pkg::OP_BWD) && (tail.col < dlts_pkg::COL_W'(dlts_pkg::RES_CAP))) begin
      obuf_r[tail.col[RI-1:0]] <= dlts_pkg::sat32(64'(tail.psum));
    end
  end

  always_comb begin
    cfg_ready        = 1'b1;
    out_valid        = stat.emit;
    out_acc          = out_valid && !out_stall;
    out_last         = stat.fwd ? (k_r == RI'(NF - 1)) : (k_r == RI'(NB - 1));
    out_result_index = k_r;
    out_result_value = stat.fwd ? res_w[0] : obuf_r[k_r];
    res_shift        = out_acc && stat.fwd;
    emit_done        = out_acc && out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= dlts_pkg::LR_RESET;
      k_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lr_r <= cfg_data;
      end
      if (emit_done) begin
        k_r <= '0;
      end else if (out_acc) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  `DLTS_AST_NOW(a_idle_no_out, !in_stall, !out_valid)
  `DLTS_AST_NEXT(a_last_ends_run, out_valid && !out_stall && out_last, !out_valid)
  `DLTS_AST_NEXT(a_write_no_work, in_valid && !in_stall && in_kind == dlts_pkg::KIND_WEIGHT,
                 !in_stall)

endmodule
